// ----- src/mt_pkg.sv -----
// Shared definitions for the MT19937 generator: table geometry, scheme constants,
// controller state type, controller/datapath command/status structs, output tempering.
// No dependencies.
package mt_pkg;

  localparam int STATE_WORDS  = 624;
  localparam int SHIFT_OFFSET = 397;
  localparam int IDX_W        = $clog2(STATE_WORDS);
  localparam int FAR_WRAP     = STATE_WORDS - SHIFT_OFFSET;

  localparam logic [31:0] MATRIX_WORD = 32'h9908_b0df;
  localparam logic [31:0] SEED_MULT   = 32'd1812433253;
  localparam logic [31:0] TEMPER_B    = 32'h9d2c_5680;
  localparam logic [31:0] TEMPER_C    = 32'hefc6_0000;
  localparam logic [31:0] RESET_SEED  = 32'd5489;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(STATE_WORDS - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEED,
    ST_ISSUE,
    ST_TWIST
  } mt_state_t;

  typedef struct packed {
    logic load_seed;
    logic seed_step;
    logic twist;
  } mt_cmd_t;

  typedef struct packed {
    logic seed_last;
  } mt_status_t;

  // Output tempering of one table word.
  function automatic logic [31:0] mt_temper(input logic [31:0] w);
    logic [31:0] y;
    y = w ^ (w >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage

// ----- src/mt_ram.sv -----
// Generic single-write, dual-read RAM with registered read data.
// No dependencies.
module mt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 624
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ----- src/mt_ctrl.sv -----
// Controller state machine for the MT19937 generator.
// Depends on mt_pkg.
module mt_ctrl
  import mt_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic       op,
  input  mt_status_t status,
  output mt_cmd_t    cmd,
  output logic       busy
);

  mt_state_t state;
  mt_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_SEED;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = op ? ST_SEED : ST_ISSUE;
        end
      end
      ST_SEED: begin
        if (status.seed_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_ISSUE: state_next = ST_TWIST;
      ST_TWIST: state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state)
      ST_IDLE: begin
        busy          = 1'b0;
        cmd.load_seed = start && op;
      end
      ST_SEED:  cmd.seed_step = 1'b1;
      ST_ISSUE: cmd           = '0;
      ST_TWIST: cmd.twist     = 1'b1;
      default:  busy          = 1'b1;
    endcase
  end

endmodule

// ----- src/mt_datapath.sv -----
// Datapath of the MT19937 generator: state table, seeding recurrence,
// per-word twist and output tempering.
// Depends on mt_pkg and mt_ram.
module mt_datapath
  import mt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  mt_cmd_t     cmd,
  input  logic [31:0] seed_value,
  output mt_status_t  status,
  output logic        done,
  output logic [30:0] random_value
);

  logic [31:0]      seed_word;
  logic [31:0]      seed_word_next;
  logic [31:0]      seed_mixed;
  logic [31:0]      seed_prod;
  logic [IDX_W-1:0] seed_addr;
  logic [IDX_W-1:0] read_index;
  logic [IDX_W-1:0] next_addr;
  logic [IDX_W-1:0] far_addr;
  logic [31:0]      cur_word;
  logic [31:0]      rd_next;
  logic [31:0]      rd_far;
  logic [31:0]      mix_y;
  logic [31:0]      twisted;
  logic [31:0]      tempered;
  logic             we;
  logic [IDX_W-1:0] waddr;
  logic [31:0]      wdata;

  // The table is twisted lazily: each draw twists exactly the word it returns.
  // Walking the words in order gives the same values as a whole-table twist,
  // since every word ahead of the index is still untwisted and every word
  // behind it already carries its new value.
  assign next_addr = (read_index == LAST_IDX) ? '0 : read_index + IDX_W'(1);
  assign far_addr  = (read_index < IDX_W'(FAR_WRAP)) ?
                     read_index + IDX_W'(SHIFT_OFFSET) :
                     read_index - IDX_W'(FAR_WRAP);

  assign seed_mixed     = seed_word ^ (seed_word >> 30);
  assign seed_prod      = SEED_MULT * seed_mixed;
  assign seed_word_next = seed_prod + 32'(seed_addr) + 32'd1;

  assign mix_y    = {cur_word[31], rd_next[30:0]};
  assign twisted  = rd_far ^ (mix_y >> 1) ^ (mix_y[0] ? MATRIX_WORD : 32'd0);
  assign tempered = mt_temper(twisted);

  assign we    = cmd.seed_step || cmd.twist;
  assign waddr = cmd.seed_step ? seed_addr : read_index;
  assign wdata = cmd.seed_step ? seed_word : twisted;

  assign status.seed_last = (seed_addr == LAST_IDX);

  mt_ram #(
    .WIDTH(32),
    .DEPTH(STATE_WORDS)
  ) u_table (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (next_addr),
    .raddr_b (far_addr),
    .rdata_a (rd_next),
    .rdata_b (rd_far)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      seed_word  <= RESET_SEED;
      seed_addr  <= '0;
      read_index <= '0;
      done       <= 1'b0;
    end else begin
      done <= cmd.twist;
      if (cmd.load_seed) begin
        seed_word  <= seed_value;
        seed_addr  <= '0;
        read_index <= '0;
      end else if (cmd.seed_step) begin
        seed_word <= seed_word_next;
        seed_addr <= status.seed_last ? '0 : seed_addr + IDX_W'(1);
      end else if (cmd.twist) begin
        read_index <= next_addr;
      end
    end
  end

  // cur_word always holds the current value of the word at the read index.
  always_ff @(posedge clk) begin
    if (cmd.seed_step && seed_addr == '0) begin
      cur_word <= seed_word;
    end else if (cmd.twist) begin
      cur_word <= rd_next;
    end
    if (cmd.twist) begin
      random_value <= tempered[30:0];
    end
  end

endmodule

// ----- src/mersenne_twister_prng.sv -----
// MT19937 generator, 31-bit output. A draw is accepted when start is high and busy
// is low; it goes through a table read, then the twist and write, and its result is
// then on the ports with done. Busy holds off a new item until the last is through.
// A seed item keeps busy high while it fills the table, one table word per cycle
// through one multiplier; it gives no result. Reset seeds the table from 5489 in the
// same way, then the first draw twists word 0 first.
module mersenne_twister_prng
  import mt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        op,
  input  logic [31:0] seed_value,
  output logic        busy,
  output logic        done,
  output logic [30:0] random_value
);

  mt_cmd_t    cmd;
  mt_status_t status;

  mt_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .op     (op),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  mt_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .seed_value   (seed_value),
    .status       (status),
    .done         (done),
    .random_value (random_value)
  );

endmodule

// ----- src/mt_checker.sv -----
// Port-level checks for the MT19937 generator, bound to the top level.
// Depends on mersenne_twister_prng.
module mt_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        op,
  input logic        busy,
  input logic        done
);

  // A draw transfer produces its result after the table read and the twist and write.
  a_draw_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && !op) |-> ##3 done)
    else $error("draw result not delivered on time");

  // A seed transfer goes busy and does not strobe a result as it starts.
  a_seed_silent: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && op) |-> ##1 (!done && busy))
    else $error("seed item produced a result or did not go busy");

  // A result appears only once the block is free again.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> (!busy && $past(busy)))
    else $error("result strobe while busy");

  // Reset starts the self-seeding pass.
  a_reset_seeds: assert property (@(posedge clk)
    $past(rst) && !rst |-> (busy && !done))
    else $error("no seeding pass after reset");

endmodule

bind mersenne_twister_prng mt_checker u_mt_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .op    (op),
  .busy  (busy),
  .done  (done)
);
